// File: sv/dbp_pkg.sv
`timescale 1ns / 1ps
package dbp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 17;
  localparam int DIV_STEPS  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd7;

  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [7:0]  RST_SAMPLE_STEP  = 8'd1;
  localparam logic [16:0] RST_MAX_POINTS   = 17'd65536;
  localparam logic [31:0] RST_INV_FOCAL    = 32'd8589934;
  localparam logic [15:0] RST_CENTER_X     = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y     = 16'd3840;

  localparam logic [COUNT_W-1:0] POINT_LIMIT = 17'd65536;
  localparam logic [15:0] DEPTH_MIN_MM = 16'd10;
  localparam logic [15:0] DEPTH_MAX_MM = 16'd50000;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic accept;
    logic load_point;
    logic load_sum;
  } dbp_cmd_t;

  typedef struct packed {
    logic keep_now;
    logic frame_end_now;
    logic frame_end_r;
    logic out_free;
    logic div_busy;
  } dbp_status_t;

endpackage

// File: sv/dbp_div.sv
`timescale 1ns / 1ps
module dbp_div
  import dbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic [31:0]        quotient
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic [STEP_W-1:0]  steps_r;
  logic [COUNT_W-1:0] rem_r;
  logic [31:0]        quo_r;
  logic [COUNT_W-1:0] div_r;
  logic [COUNT_W:0]   rem_sh;
  logic               q_bit;
  logic [COUNT_W:0]   rem_sub;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[31]};
    q_bit   = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else if (start) begin
      steps_r <= STEP_W'(DIV_STEPS);
    end else if (busy) begin
      steps_r <= steps_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy) begin
      rem_r <= q_bit ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      quo_r <= {quo_r[30:0], q_bit};
    end
  end

  assign busy     = steps_r != '0;
  assign quotient = quo_r;

endmodule

// File: sv/dbp_datapath.sv
`timescale 1ns / 1ps
module dbp_datapath
  import dbp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dbp_cmd_t              cmd,
  output dbp_status_t           status,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [15:0]           in_depth_mm,
  input  logic                  in_depth_not_finite,
  input  logic [7:0]            in_pixel_intensity,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic signed [31:0]    out_point_x_mm,
  output logic signed [31:0]    out_point_y_mm,
  output logic [15:0]           out_point_z_mm,
  output logic [7:0]            out_point_intensity,
  output logic [COUNT_W-1:0]    out_frame_point_count,
  output logic [15:0]           out_mean_depth_mm,
  output logic                  out_last_of_item
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > 13) ? DIM_W : 13;
  localparam int POS_W = IDX_W + 4;
  localparam int MAG_W = (POS_W > 16) ? POS_W : 16;
  localparam int P1_W  = MAG_W + 16;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

  // configuration
  logic [12:0] frame_width_r, frame_height_r;
  logic [7:0]  sample_step_r;
  logic [16:0] max_points_r;
  logic [31:0] inv_focal_x_r, inv_focal_y_r;
  logic [15:0] center_x_r, center_y_r;

  // raster position and frame totals
  logic [IDX_W-1:0]   col_r, row_r;
  logic [7:0]         cph_r, rph_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [31:0]        total_r;

  // held pixel and projection pipeline
  logic [15:0]        z_r;
  logic [7:0]         inten_r;
  logic [MAG_W-1:0]   mag_x_r, mag_y_r;
  logic               neg_x_r, neg_y_r;
  logic               frame_end_r;
  logic [COUNT_W-1:0] sum_count_r;
  logic [P1_W-1:0]    p1_x_r, p1_y_r;
  logic [63:0]        p2_x_r, p2_y_r;

  // result register
  logic               out_valid_r;
  logic               kind_r;
  logic [31:0]        x_r, y_r;
  logic [15:0]        oz_r;
  logic [7:0]         oint_r;
  logic [COUNT_W-1:0] ocnt_r;
  logic [15:0]        mean_r;
  logic               last_r;

  logic [CMP_W-1:0]   w_raw, h_raw, w_eff, h_eff, col_inc, row_inc;
  logic [7:0]         step_eff;
  logic [COUNT_W-1:0] limit_eff, cnt_inc;
  logic [8:0]         cph_inc, rph_inc;
  logic               cph_wrap, rph_wrap;
  logic               row_end, frame_end, keep;
  logic [32:0]        total_sum;
  logic [31:0]        total_add;
  logic [MAG_W-1:0]   pos_x, pos_y, cen_x, cen_y;
  logic               neg_x, neg_y;
  logic [MAG_W-1:0]   mag_x, mag_y;
  logic [31:0]        m_x, m_y;
  logic [27:0]        r_x, r_y;
  logic [31:0]        proj_x, proj_y;
  logic               div_busy;
  logic [31:0]        quotient;
  logic [31:0]        div_dividend;
  logic [COUNT_W-1:0] div_divisor;
  logic               out_taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      sample_step_r  <= RST_SAMPLE_STEP;
      max_points_r   <= RST_MAX_POINTS;
      inv_focal_x_r  <= RST_INV_FOCAL;
      inv_focal_y_r  <= RST_INV_FOCAL;
      center_x_r     <= RST_CENTER_X;
      center_y_r     <= RST_CENTER_Y;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wr_data[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data[12:0];
        CFG_SAMPLE_STEP:  sample_step_r  <= cfg_wr_data[7:0];
        CFG_MAX_POINTS:   max_points_r   <= cfg_wr_data[16:0];
        CFG_INV_FOCAL_X:  inv_focal_x_r  <= cfg_wr_data;
        CFG_INV_FOCAL_Y:  inv_focal_y_r  <= cfg_wr_data;
        CFG_CENTER_X:     center_x_r     <= cfg_wr_data[15:0];
        CFG_CENTER_Y:     center_y_r     <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // effective limits and position bookkeeping for the pixel on the input
  always_comb begin
    w_raw = CMP_W'(frame_width_r);
    h_raw = CMP_W'(frame_height_r);
    if (w_raw == '0) w_eff = CMP_W'(1);
    else if (w_raw > MAX_DIM_C) w_eff = MAX_DIM_C;
    else w_eff = w_raw;
    if (h_raw == '0) h_eff = CMP_W'(1);
    else if (h_raw > MAX_DIM_C) h_eff = MAX_DIM_C;
    else h_eff = h_raw;

    step_eff = (sample_step_r == 8'd0) ? 8'd1 : sample_step_r;
    if (max_points_r == '0) limit_eff = COUNT_W'(1);
    else if (max_points_r > POINT_LIMIT) limit_eff = POINT_LIMIT;
    else limit_eff = max_points_r;

    col_inc   = CMP_W'(col_r) + CMP_W'(1);
    row_inc   = CMP_W'(row_r) + CMP_W'(1);
    row_end   = col_inc >= w_eff;
    frame_end = row_end && (row_inc >= h_eff);

    cph_inc  = {1'b0, cph_r} + 9'd1;
    rph_inc  = {1'b0, rph_r} + 9'd1;
    cph_wrap = cph_inc >= {1'b0, step_eff};
    rph_wrap = rph_inc >= {1'b0, step_eff};

    keep = (cph_r == 8'd0) && (rph_r == 8'd0) && !in_depth_not_finite &&
           (in_depth_mm > DEPTH_MIN_MM) && (in_depth_mm <= DEPTH_MAX_MM) &&
           (cnt_r < limit_eff);

    cnt_inc   = cnt_r + COUNT_W'(1);
    total_sum = {1'b0, total_r} + 33'(in_depth_mm);
    total_add = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

    pos_x = MAG_W'({col_r, 4'b0000});
    pos_y = MAG_W'({row_r, 4'b0000});
    cen_x = MAG_W'(center_x_r);
    cen_y = MAG_W'(center_y_r);
    neg_x = cen_x > pos_x;
    neg_y = cen_y > pos_y;
    mag_x = neg_x ? cen_x - pos_x : pos_x - cen_x;
    mag_y = neg_y ? cen_y - pos_y : pos_y - cen_y;

    div_dividend = keep ? total_add : total_r;
    div_divisor  = keep ? cnt_inc : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cph_r       <= '0;
      rph_r       <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      frame_end_r <= 1'b0;
    end else if (cmd.accept) begin
      frame_end_r <= frame_end;
      if (frame_end) begin
        col_r   <= '0;
        row_r   <= '0;
        cph_r   <= '0;
        rph_r   <= '0;
        cnt_r   <= '0;
        total_r <= '0;
      end else begin
        if (row_end) begin
          col_r <= '0;
          cph_r <= '0;
          row_r <= row_inc[IDX_W-1:0];
          rph_r <= rph_wrap ? 8'd0 : rph_inc[7:0];
        end else begin
          col_r <= col_inc[IDX_W-1:0];
          cph_r <= cph_wrap ? 8'd0 : cph_inc[7:0];
        end
        if (keep) begin
          cnt_r   <= cnt_inc;
          total_r <= total_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      z_r         <= in_depth_mm;
      inten_r     <= in_pixel_intensity;
      mag_x_r     <= mag_x;
      mag_y_r     <= mag_y;
      neg_x_r     <= neg_x;
      neg_y_r     <= neg_y;
      sum_count_r <= div_divisor;
    end
  end

  // two multiplier stages; operands hold from the accept on
  always_comb begin
    m_x    = (p1_x_r > P1_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : p1_x_r[31:0];
    m_y    = (p1_y_r > P1_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : p1_y_r[31:0];
    r_x    = p2_x_r[63:36];
    r_y    = p2_y_r[63:36];
    proj_x = neg_x_r ? 32'd0 - {4'b0000, r_x} : {4'b0000, r_x};
    proj_y = neg_y_r ? 32'd0 - {4'b0000, r_y} : {4'b0000, r_y};
  end

  always_ff @(posedge clk) begin
    p1_x_r <= P1_W'(mag_x_r) * P1_W'(z_r);
    p1_y_r <= P1_W'(mag_y_r) * P1_W'(z_r);
    p2_x_r <= 64'(m_x) * 64'(inv_focal_x_r);
    p2_y_r <= 64'(m_y) * 64'(inv_focal_y_r);
  end

  dbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.accept & frame_end),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign out_taken = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_point || cmd.load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      kind_r <= KIND_POINT;
      x_r    <= proj_x;
      y_r    <= proj_y;
      oz_r   <= z_r;
      oint_r <= inten_r;
      ocnt_r <= '0;
      mean_r <= '0;
      last_r <= !frame_end_r;
    end else if (cmd.load_sum) begin
      kind_r <= KIND_SUMMARY;
      x_r    <= '0;
      y_r    <= '0;
      oz_r   <= '0;
      oint_r <= '0;
      ocnt_r <= sum_count_r;
      mean_r <= (sum_count_r == '0) ? 16'd0 : quotient[15:0];
      last_r <= 1'b1;
    end
  end

  always_comb begin
    status.keep_now      = keep;
    status.frame_end_now = frame_end;
    status.frame_end_r   = frame_end_r;
    status.out_free      = !out_valid_r || !out_stall;
    status.div_busy      = div_busy;
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = kind_r;
  assign out_point_x_mm        = x_r;
  assign out_point_y_mm        = y_r;
  assign out_point_z_mm        = oz_r;
  assign out_point_intensity   = oint_r;
  assign out_frame_point_count = ocnt_r;
  assign out_mean_depth_mm     = mean_r;
  assign out_last_of_item      = last_r;

endmodule

// File: sv/dbp_ctrl.sv
`timescale 1ns / 1ps
module dbp_ctrl
  import dbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dbp_status_t status,
  output dbp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_A = 6'b000010,
    S_MUL_B = 6'b000100,
    S_POINT = 6'b001000,
    S_SUM   = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd.accept     = 1'b0;
    cmd.load_point = 1'b0;
    cmd.load_sum   = 1'b0;
    in_stall       = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.keep_now) state_nxt = S_MUL_A;
          else if (status.frame_end_now) state_nxt = S_SUM;
        end
      end
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = S_POINT;
      S_POINT: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.load_point = 1'b1;
          state_nxt      = status.frame_end_r ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (status.out_free && !status.div_busy) begin
          cmd.load_sum = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/depth_pixel_back_projection_core.sv
`timescale 1ns / 1ps
// Depth pixel back-projection. Pixels enter row by row on the in_ channel
// (valid/stall), one beat per pixel; result beats leave on the out_ channel.
// A sampled pixel with a usable depth under the point limit gives a point
// beat (kind 0); the last pixel of a frame also gives a summary beat
// (kind 1) with the point count and mean depth, after the point if there
// is one. out_last_of_item marks the final beat a pixel causes.
// Timing: a pixel that gives no point and does not end the frame is taken
// without raising in_stall. A kept pixel passes two multiplier stages per
// axis (offset times depth, then times the reciprocal focal length) and the
// load of the result register, which waits until that register is free.
// The frame's last pixel waits for the 32-step serial mean divider.
// A stalled result holds in the output register; the block keeps accepting
// pixels that give no beat, and in_stall is high while a kept pixel or a
// summary is in work.
// Reset (rst_n low, synchronous) restores the default registers, clears the
// raster position and frame totals and empties the output register.
// cfg_wr_en writes register cfg_index from cfg_wr_data; write only when idle.
module depth_pixel_back_projection_core
  import dbp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_depth_mm,
  input  logic                  in_depth_not_finite,
  input  logic [7:0]            in_pixel_intensity,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic signed [31:0]    out_point_x_mm,
  output logic signed [31:0]    out_point_y_mm,
  output logic [15:0]           out_point_z_mm,
  output logic [7:0]            out_point_intensity,
  output logic [COUNT_W-1:0]    out_frame_point_count,
  output logic [15:0]           out_mean_depth_mm,
  output logic                  out_last_of_item
);

  dbp_cmd_t    cmd;
  dbp_status_t status;

  dbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dbp_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wr_data           (cfg_wr_data),
    .in_depth_mm           (in_depth_mm),
    .in_depth_not_finite   (in_depth_not_finite),
    .in_pixel_intensity    (in_pixel_intensity),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_point_x_mm        (out_point_x_mm),
    .out_point_y_mm        (out_point_y_mm),
    .out_point_z_mm        (out_point_z_mm),
    .out_point_intensity   (out_point_intensity),
    .out_frame_point_count (out_frame_point_count),
    .out_mean_depth_mm     (out_mean_depth_mm),
    .out_last_of_item      (out_last_of_item)
  );

endmodule
